// ===== rtl/core/numlit_pkg.sv =====
// Shared types, character codes and decode functions for the numeric literal classifier.
// Used by numeric_literal_classifier and its port checker; depends on nothing else.
`timescale 1ns / 1ps

package numlit_pkg;

   localparam int CODE_W  = 16;
   localparam int CLASS_W = 2;

   // Character codes that the decoder looks at.
   localparam logic [CODE_W-1:0] CHAR_NUL   = 16'h0000;
   localparam logic [CODE_W-1:0] CHAR_PLUS  = 16'h002B;
   localparam logic [CODE_W-1:0] CHAR_MINUS = 16'h002D;
   localparam logic [CODE_W-1:0] CHAR_POINT = 16'h002E;
   localparam logic [CODE_W-1:0] CHAR_ZERO  = 16'h0030;
   localparam logic [CODE_W-1:0] CHAR_ONE   = 16'h0031;
   localparam logic [CODE_W-1:0] CHAR_EIGHT = 16'h0038;
   localparam logic [CODE_W-1:0] CHAR_NINE  = 16'h0039;
   localparam logic [CODE_W-1:0] CHAR_UP_A  = 16'h0041;
   localparam logic [CODE_W-1:0] CHAR_UP_E  = 16'h0045;
   localparam logic [CODE_W-1:0] CHAR_UP_F  = 16'h0046;
   localparam logic [CODE_W-1:0] CHAR_UP_X  = 16'h0058;
   localparam logic [CODE_W-1:0] CHAR_LO_A  = 16'h0061;
   localparam logic [CODE_W-1:0] CHAR_LO_E  = 16'h0065;
   localparam logic [CODE_W-1:0] CHAR_LO_F  = 16'h0066;
   localparam logic [CODE_W-1:0] CHAR_LO_X  = 16'h0078;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_STRING = 2'd0,
      CLASS_INT    = 2'd1,
      CLASS_FLOAT  = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      BASE_NONE = 2'd0,
      BASE_DEC  = 2'd1,
      BASE_HEX  = 2'd2,
      BASE_OCT  = 2'd3
   } base_type;

   typedef enum logic [6:0] {
      PH_START  = 7'b0000001,
      PH_ZERO   = 7'b0000010,
      PH_ZERO_X = 7'b0000100,
      PH_BODY   = 7'b0001000,
      PH_POINT  = 7'b0010000,
      PH_E      = 7'b0100000,
      PH_ESIGN  = 7'b1000000
   } phase_type;

   // What one body character does to the running state.
   typedef struct packed {
      phase_type phase;
      logic      point_seen;
      logic      reject;
   } body_res_type;

   function automatic logic is_dig(input logic [CODE_W-1:0] c);
      return c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

   function automatic logic is_sign(input logic [CODE_W-1:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS);
   endfunction

   function automatic logic is_e(input logic [CODE_W-1:0] c);
      return (c == CHAR_LO_E) || (c == CHAR_UP_E);
   endfunction

   function automatic logic is_hex_letter(input logic [CODE_W-1:0] c);
      return c inside {[CHAR_LO_A:CHAR_LO_F], [CHAR_UP_A:CHAR_UP_F]};
   endfunction

   function automatic body_res_type body_step(input logic [CODE_W-1:0] c,
                                              input base_type          base,
                                              input logic              point_seen,
                                              input logic              exp_seen);
      body_res_type res;
      res.phase      = PH_BODY;
      res.point_seen = point_seen;
      res.reject     = 1'b0;
      if (is_sign(c)) begin
         res.reject = 1'b1;
      end else if (c == CHAR_POINT) begin
         if (point_seen) begin
            res.reject = 1'b1;
         end else begin
            res.point_seen = 1'b1;
            res.phase      = PH_POINT;
         end
      end else if (is_e(c)) begin
         res.phase = PH_E;
      end else if (is_hex_letter(c)) begin
         res.reject = (base == BASE_DEC) || exp_seen;
      end else if (is_dig(c)) begin
         res.reject = (base == BASE_OCT) && (c >= CHAR_EIGHT);
      end else begin
         res.reject = 1'b1;
      end
      return res;
   endfunction

   function automatic class_type final_class(input base_type base,
                                             input logic     point_seen,
                                             input logic     exp_seen);
      logic frac;
      frac = point_seen || exp_seen;
      if ((base == BASE_DEC) && frac) begin
         return CLASS_FLOAT;
      end else if ((base != BASE_NONE) && !frac) begin
         return CLASS_INT;
      end
      return CLASS_STRING;
   endfunction

endpackage

// ===== rtl/core/numeric_literal_classifier.sv =====
// Numeric literal classifier: decodes a character stream into string, integer or float.
// Depends on numlit_pkg for character codes, state codes and decode functions.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_stall     | req_code (16 bits, 0 ends the string)
//  rsp     | out       | rsp_valid / rsp_stall     | rsp_class_res (2 bits)
//
// One character is taken every clock while req_stall is low; the state flops update in the cycle of acceptance.
// A terminator puts its class in the result register, visible in the next cycle.
// req_stall rises only while a result waits in the result register and rsp_stall is high.
// Synchronous active-high reset returns the decoder to the start of a string.

module numeric_literal_classifier
   import numlit_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CODE_W-1:0]  req_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CLASS_W-1:0] rsp_class_res
);

   phase_type phase_ff, phase_in;
   base_type  base_ff, base_in;
   logic      sign_seen_ff, sign_seen_in;
   logic      point_seen_ff, point_seen_in;
   logic      exp_seen_ff, exp_seen_in;
   logic      exp_sign_seen_ff, exp_sign_seen_in;
   logic      rejected_ff, rejected_in;
   logic      rsp_valid_ff, rsp_valid_in;
   class_type rsp_class_ff, rsp_class_in;

   logic         req_accept;
   body_res_type body_res;
   class_type    term_class;

   assign req_stall     = rsp_valid_ff && rsp_stall;
   assign req_accept    = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_class_res = rsp_class_ff;

   // Base used by the body check: a leading 0 or 0x fixes the base in the same cycle.
   base_type body_base;

   always_comb begin
      body_base = base_ff;
      case (phase_ff)
         PH_START:  body_base = BASE_DEC;
         PH_ZERO:   body_base = (is_dig(req_code) || (req_code == CHAR_POINT)) ?
                                BASE_DEC : BASE_OCT;
         PH_ZERO_X: body_base = BASE_HEX;
         default:   body_base = base_ff;
      endcase
   end

   // An exponent digit marks the exponent before the body check sees it.
   assign body_res = body_step(req_code, body_base, point_seen_ff,
                               exp_seen_ff || ((phase_ff == PH_E) && is_dig(req_code)));

   always_comb begin
      term_class = CLASS_STRING;
      if (!rejected_ff) begin
         case (phase_ff)
            PH_ZERO:           term_class = CLASS_INT;
            PH_BODY, PH_POINT: term_class = final_class(base_ff, point_seen_ff, exp_seen_ff);
            PH_E:              term_class = (base_ff == BASE_DEC) ? CLASS_STRING :
                                            final_class(base_ff, point_seen_ff, exp_seen_ff);
            default:           term_class = CLASS_STRING;
         endcase
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      base_in          = base_ff;
      sign_seen_in     = sign_seen_ff;
      point_seen_in    = point_seen_ff;
      exp_seen_in      = exp_seen_ff;
      exp_sign_seen_in = exp_sign_seen_ff;
      rejected_in      = rejected_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_class_in     = rsp_class_ff;

      if (req_accept) begin
         if (req_code == CHAR_NUL) begin
            rsp_valid_in     = 1'b1;
            rsp_class_in     = term_class;
            phase_in         = PH_START;
            base_in          = BASE_NONE;
            sign_seen_in     = 1'b0;
            point_seen_in    = 1'b0;
            exp_seen_in      = 1'b0;
            exp_sign_seen_in = 1'b0;
            rejected_in      = 1'b0;
         end else if (!rejected_ff) begin
            case (phase_ff)
               PH_START: begin
                  if (is_sign(req_code)) begin
                     if (sign_seen_ff || point_seen_ff) begin
                        rejected_in = 1'b1;
                     end else begin
                        sign_seen_in = 1'b1;
                     end
                  end else if (req_code == CHAR_POINT) begin
                     if (point_seen_ff) begin
                        rejected_in = 1'b1;
                     end else begin
                        point_seen_in = 1'b1;
                     end
                  end else if (req_code inside {[CHAR_ONE:CHAR_NINE]}) begin
                     base_in       = BASE_DEC;
                     phase_in      = body_res.phase;
                     point_seen_in = body_res.point_seen;
                     rejected_in   = body_res.reject;
                  end else if (req_code == CHAR_ZERO) begin
                     phase_in = PH_ZERO;
                  end else begin
                     rejected_in = 1'b1;
                  end
               end
               PH_ZERO: begin
                  if ((req_code == CHAR_LO_X) || (req_code == CHAR_UP_X)) begin
                     phase_in = PH_ZERO_X;
                  end else begin
                     base_in       = body_base;
                     phase_in      = body_res.phase;
                     point_seen_in = body_res.point_seen;
                     rejected_in   = body_res.reject;
                  end
               end
               PH_ZERO_X: begin
                  if (is_dig(req_code) || is_hex_letter(req_code)) begin
                     base_in       = BASE_HEX;
                     phase_in      = body_res.phase;
                     point_seen_in = body_res.point_seen;
                     rejected_in   = body_res.reject;
                  end else begin
                     rejected_in = 1'b1;
                  end
               end
               PH_BODY: begin
                  phase_in      = body_res.phase;
                  point_seen_in = body_res.point_seen;
                  rejected_in   = body_res.reject;
               end
               PH_POINT: begin
                  if (is_dig(req_code) || is_e(req_code)) begin
                     phase_in      = body_res.phase;
                     point_seen_in = body_res.point_seen;
                     rejected_in   = body_res.reject;
                  end else begin
                     rejected_in = 1'b1;
                  end
               end
               PH_E: begin
                  if (is_sign(req_code)) begin
                     if ((base_ff == BASE_HEX) || exp_sign_seen_ff) begin
                        rejected_in = 1'b1;
                     end else begin
                        exp_sign_seen_in = 1'b1;
                        phase_in         = PH_ESIGN;
                     end
                  end else if (is_dig(req_code)) begin
                     exp_seen_in   = 1'b1;
                     phase_in      = body_res.phase;
                     point_seen_in = body_res.point_seen;
                     rejected_in   = body_res.reject;
                  end else if (base_ff == BASE_DEC) begin
                     rejected_in = 1'b1;
                  end else begin
                     phase_in      = body_res.phase;
                     point_seen_in = body_res.point_seen;
                     rejected_in   = body_res.reject;
                  end
               end
               PH_ESIGN: begin
                  if (is_dig(req_code)) begin
                     exp_seen_in = 1'b1;
                     phase_in    = PH_BODY;
                  end else begin
                     rejected_in = 1'b1;
                  end
               end
               default: begin
                  rejected_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_START;
         base_ff          <= BASE_NONE;
         sign_seen_ff     <= 1'b0;
         point_seen_ff    <= 1'b0;
         exp_seen_ff      <= 1'b0;
         exp_sign_seen_ff <= 1'b0;
         rejected_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         base_ff          <= base_in;
         sign_seen_ff     <= sign_seen_in;
         point_seen_ff    <= point_seen_in;
         exp_seen_ff      <= exp_seen_in;
         exp_sign_seen_ff <= exp_sign_seen_in;
         rejected_ff      <= rejected_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_ff <= rsp_class_in;
   end

endmodule

// ===== rtl/core/numlit_checker.sv =====
// Port-level assertions for numeric_literal_classifier, attached by the bind below.
// Depends on numlit_pkg for the character and class codes.
`timescale 1ns / 1ps

module numlit_checker
   import numlit_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [CODE_W-1:0]  req_code,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [CLASS_W-1:0] rsp_class_res
);

   // A waiting result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_class_res))
      else $error("result changed while stalled");

   // Only the three defined classes ever leave the block.
   a_class_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_class_res == CLASS_STRING) || (rsp_class_res == CLASS_INT) ||
                    (rsp_class_res == CLASS_FLOAT))
      else $error("undefined class code");

   // A terminator that is taken gives a result in the next cycle.
   a_term_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_code == CHAR_NUL) |=> rsp_valid)
      else $error("terminator gave no result");

   // Any other character gives no result.
   a_char_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_code != CHAR_NUL) && !(rsp_valid && rsp_stall)
      |=> !rsp_valid)
      else $error("result without terminator");

   // The input is held back only while a result waits downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

endmodule

bind numeric_literal_classifier numlit_checker u_numlit_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_code      (req_code),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_class_res (rsp_class_res)
);

// ===== sim/tb_top.sv =====
// Testbench for numeric_literal_classifier: sends strings and checks each class it reports.
// Depends on numlit_pkg and the classifier RTL; holds its own model of the decoder.
`timescale 1ns / 1ps

module tb_top;
   import numlit_pkg::*;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [CODE_W-1:0]  req_code      = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic [CLASS_W-1:0] rsp_class_res;

   numeric_literal_classifier i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code      (req_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_class_res (rsp_class_res)
   );

   always #6 clock = ~clock;

   // Decoder model state.
   phase_type ph;
   base_type  num_base;
   logic      lead_sign, got_point, got_exp, got_exp_sign, dropped;

   class_type         class_fifo[$];
   logic [CODE_W-1:0] lit_buf[$];
   int                fail_count = 0;
   int                items_sent = 0;
   bit                idle_on    = 1'b1;

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   function automatic bit digit_char(input logic [CODE_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic bit sign_char(input logic [CODE_W-1:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS);
   endfunction

   function automatic bit exp_letter(input logic [CODE_W-1:0] c);
      return (c == CHAR_LO_E) || (c == CHAR_UP_E);
   endfunction

   function automatic bit hex_letter(input logic [CODE_W-1:0] c);
      return ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
   endfunction

   task automatic clear_literal_state();
      ph           = PH_START;
      num_base     = BASE_NONE;
      lead_sign    = 1'b0;
      got_point    = 1'b0;
      got_exp      = 1'b0;
      got_exp_sign = 1'b0;
      dropped      = 1'b0;
   endtask

   function automatic class_type number_class();
      bit fractional;
      fractional = got_point || got_exp;
      if (num_base == BASE_DEC && fractional)
         return CLASS_FLOAT;
      if (num_base != BASE_NONE && !fractional)
         return CLASS_INT;
      return CLASS_STRING;
   endfunction

   // One character of the literal body once the base is known.
   task automatic body_char(input logic [CODE_W-1:0] c);
      ph = PH_BODY;
      if (sign_char(c)) begin
         dropped = 1'b1;
      end else if (c == CHAR_POINT) begin
         if (got_point) begin
            dropped = 1'b1;
         end else begin
            got_point = 1'b1;
            ph        = PH_POINT;
         end
      end else if (exp_letter(c)) begin
         ph = PH_E;
      end else if (hex_letter(c)) begin
         if (num_base == BASE_DEC || got_exp)
            dropped = 1'b1;
      end else if (digit_char(c)) begin
         if (num_base == BASE_OCT && c >= CHAR_EIGHT)
            dropped = 1'b1;
      end else begin
         dropped = 1'b1;
      end
   endtask

   task automatic predict_code(input logic [CODE_W-1:0] c, output bit emits,
                               output class_type cls);
      emits = 1'b0;
      cls   = CLASS_STRING;
      if (c == CHAR_NUL) begin
         emits = 1'b1;
         if (!dropped) begin
            case (ph)
               PH_ZERO:           cls = CLASS_INT;
               PH_BODY, PH_POINT: cls = number_class();
               PH_E:              cls = (num_base == BASE_DEC) ? CLASS_STRING : number_class();
               default:           cls = CLASS_STRING;
            endcase
         end
         clear_literal_state();
      end else if (!dropped) begin
         case (ph)
            PH_START: begin
               if (sign_char(c)) begin
                  if (lead_sign || got_point) dropped = 1'b1;
                  else lead_sign = 1'b1;
               end else if (c == CHAR_POINT) begin
                  if (got_point) dropped = 1'b1;
                  else got_point = 1'b1;
               end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
                  num_base = BASE_DEC;
                  body_char(c);
               end else if (c == CHAR_ZERO) begin
                  ph = PH_ZERO;
               end else begin
                  dropped = 1'b1;
               end
            end
            PH_ZERO: begin
               if (c == CHAR_LO_X || c == CHAR_UP_X) begin
                  ph = PH_ZERO_X;
               end else begin
                  num_base = (digit_char(c) || c == CHAR_POINT) ? BASE_DEC : BASE_OCT;
                  body_char(c);
               end
            end
            PH_ZERO_X: begin
               if (digit_char(c) || hex_letter(c)) begin
                  num_base = BASE_HEX;
                  body_char(c);
               end else begin
                  dropped = 1'b1;
               end
            end
            PH_BODY: body_char(c);
            PH_POINT: begin
               if (digit_char(c) || exp_letter(c)) body_char(c);
               else dropped = 1'b1;
            end
            PH_E: begin
               if (sign_char(c)) begin
                  if (num_base == BASE_HEX || got_exp_sign) begin
                     dropped = 1'b1;
                  end else begin
                     got_exp_sign = 1'b1;
                     ph           = PH_ESIGN;
                  end
               end else if (digit_char(c)) begin
                  got_exp = 1'b1;
                  body_char(c);
               end else if (num_base == BASE_DEC) begin
                  dropped = 1'b1;
               end else begin
                  body_char(c);
               end
            end
            PH_ESIGN: begin
               if (digit_char(c)) begin
                  got_exp = 1'b1;
                  ph      = PH_BODY;
               end else begin
                  dropped = 1'b1;
               end
            end
            default: dropped = 1'b1;
         endcase
      end
   endtask

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_code(input logic [CODE_W-1:0] c);
      bit        emits;
      class_type cls;
      if (idle_on && $urandom_range(0, 99) < 5) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code  <= c;
      do @(posedge clock); while (req_stall);
      predict_code(c, emits, cls);
      if (emits)
         class_fifo.push_back(cls);
      items_sent++;
   endtask

   task automatic send_buffer();
      foreach (lit_buf[i])
         send_code(lit_buf[i]);
      send_code(CHAR_NUL);
   endtask

   task automatic send_text(input string s);
      lit_buf.delete();
      for (int i = 0; i < s.len(); i++)
         lit_buf.push_back(CODE_W'(s[i]));
      send_buffer();
   endtask

   function automatic logic [CODE_W-1:0] pick(input string alphabet);
      return CODE_W'(alphabet[$urandom_range(0, alphabet.len() - 1)]);
   endfunction

   task automatic add_chars(input string alphabet, input int lo, input int hi);
      repeat ($urandom_range(lo, hi))
         lit_buf.push_back(pick(alphabet));
   endtask

   // Mostly well-formed literals with random content, some noise and broken ones.
   task automatic make_literal();
      int shape;
      lit_buf.delete();
      if ($urandom_range(0, 3) == 0) lit_buf.push_back(pick("+-"));
      if ($urandom_range(0, 9) == 0) lit_buf.push_back(CHAR_POINT);
      shape = $urandom_range(0, 9);
      case (shape)
         0, 1: begin
            add_chars("123456789", 1, 1);
            add_chars("0123456789", 0, 6);
         end
         2: begin
            lit_buf.push_back(CHAR_ZERO);
            add_chars("xX", 1, 1);
            add_chars("0123456789abcdefABCDEF", 1, 6);
         end
         3: begin
            lit_buf.push_back(CHAR_ZERO);
            add_chars("01234567", 1, 5);
         end
         4, 5: begin
            add_chars("0123456789", 0, 3);
            if ($urandom_range(0, 3) != 0) lit_buf.push_back(CHAR_POINT);
            add_chars("0123456789", 0, 3);
            if ($urandom_range(0, 1) == 1) begin
               add_chars("eE", 1, 1);
               if ($urandom_range(0, 1) == 1) add_chars("+-", 1, 1);
               add_chars("0123456789", 0, 2);
            end
         end
         6: begin
            lit_buf.push_back(CHAR_ZERO);
            if ($urandom_range(0, 1) == 1) begin
               lit_buf.push_back(CHAR_POINT);
               add_chars("0123456789", 0, 2);
            end
         end
         7: begin
            lit_buf.push_back(CHAR_ZERO);
            add_chars("xX", 1, 1);
            add_chars("0123456789abcdef", 1, 2);
            add_chars("eE", 1, 1);
            if ($urandom_range(0, 2) == 0) add_chars("+-", 1, 1);
            add_chars("0123456789", 0, 2);
         end
         8: add_chars("+-.eExX0123456789aF_ z", 1, 8);
         default: begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 1)
                  lit_buf.push_back(CODE_W'($urandom_range(1, 65535)));
               else
                  lit_buf.push_back(pick("0123456789."));
            end
         end
      endcase
      // Occasionally corrupt one character.
      if (lit_buf.size() != 0 && $urandom_range(0, 7) == 0) begin
         if ($urandom_range(0, 1) == 1)
            lit_buf[$urandom_range(0, lit_buf.size() - 1)] = pick("+-.eExX89gG ");
         else
            lit_buf[$urandom_range(0, lit_buf.size() - 1)] = CODE_W'($urandom_range(1, 65535));
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (class_fifo.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_and_zero();
      send_text("");
      send_text(".0");
   endtask

   task automatic test_rejections();
      send_text("-x");
      send_text("1+");
      send_text("1.x");
      // Highest code after a digit.
      send_code(CODE_W'("7"));
      send_code(16'hFFFF);
      send_code(CHAR_NUL);
   endtask

   task automatic test_exponents();
      send_text("0xe1");
      send_text("1e-2");
   endtask

   task automatic test_pause_until_drained();
      repeat (3) begin
         repeat (5) begin
            make_literal();
            send_buffer();
         end
         wait_for_results();
         @(posedge clock);
      end
   endtask

   task automatic test_steady_stream();
      int stop_at;
      stop_at = items_sent + 250;
      idle_on = 1'b0;
      while (items_sent < stop_at) begin
         make_literal();
         send_buffer();
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_literals();
      while (items_sent < 1300) begin
         make_literal();
         send_buffer();
      end
   endtask

   always @(posedge clock)
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 11);

   always @(posedge clock) begin : check_results
      class_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (class_fifo.size() == 0) begin
            report_mismatch($sformatf("class %0d reported with no string pending",
                                      rsp_class_res));
         end else begin
            want = class_fifo.pop_front();
            if (rsp_class_res !== want)
               report_mismatch($sformatf("class_res is %0d, expected %s",
                                         rsp_class_res, want.name()));
         end
      end
   end

   initial begin
      clear_literal_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_zero();
      test_rejections();
      test_exponents();
      test_pause_until_drained();
      test_steady_stream();
      test_random_literals();
      wait_for_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", class_fifo.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
